>>> rtl/twirl_pkg.sv
// ----------------------------------------------------------------------------
// twirl_pkg
// Shared types and constants of the twirl source coordinate core: register
// map, fixed-point constants and reciprocals for constant division.
// ----------------------------------------------------------------------------
package twirl_pkg;

	// largest grid side the core maps; larger sizes clamp to it
	localparam int MAX_GRID = 256;

	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH     = 2'd0,
		REG_GRID_HEIGHT    = 2'd1,
		REG_TWIRL_STRENGTH = 2'd2
	} reg_idx_t;

	typedef logic signed [10:0] off_t;   // Q.1 offset from grid center

	localparam logic [15:0] LN2_Q16     = 16'd45426;
	localparam logic [20:0] TWO_PI_Q16  = 21'd411775;
	localparam logic [20:0] HALF_PI_Q16 = 21'd102944;

	// ceil(2^28 / 11): exact floor division by 11 for 24-bit dividends
	localparam logic [24:0] RECIP_11  = 25'(((64'd1 << 28) + 64'd10) / 64'd11);
	// ceil(2^37 / 45426): exact floor division by ln2 for 21-bit dividends
	localparam logic [21:0] RECIP_LN2 = 22'(((64'd1 << 37) + 64'd45425) / 64'd45426);

endpackage

>>> rtl/twirl_warp_source_coordinate_core.sv
// ----------------------------------------------------------------------------
// twirl_warp_source_coordinate_core
// Twirl inverse map: rotates each output pixel about the grid center by an
// angle that decays exponentially with radius and returns the source pixel.
//
//  channel   | direction | signals                         | contents
//  ----------+-----------+---------------------------------+---------------------
//  s_axis    | in        | tvalid tready tdata[15:0]       | out_x, out_y
//  m_axis    | out       | tvalid tready tdata[23:0] tuser | src_x, src_y / inside
//  apb       | in        | psel penable pwrite paddr ...   | grid size, strength
//
// One transaction per cycle sustained while the output buffer is not full.
// The pipeline depth is set by the 17-stage square root and the exp and sin/cos
// Taylor chains, two stages (multiply, divide by term index) per term.
// A two-entry output buffer takes results; the whole pipeline freezes only
// when both entries are held. Reset clears valid bits and strength; sizes reset to 64.
// ----------------------------------------------------------------------------
module twirl_warp_source_coordinate_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [twirl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,   // out_x[7:0], out_y[15:8]
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [23:0]                    m_axis_tdata,   // src_x[9:0], src_y[19:10], zero
	output logic [0:0]                     m_axis_tuser    // src_inside
);

	localparam int SQ_N  = 17;
	localparam int EX_N  = 12;
	localparam int SN_N  = 13;
	localparam int P_SQ  = 3;
	localparam int P_U   = P_SQ + SQ_N;
	localparam int P_N   = P_U + 1;
	localparam int P_G   = P_N + 1;
	localparam int P_EX  = P_G + 1;
	localparam int P_E   = P_EX + 2 * EX_N;
	localparam int P_A   = P_E + 1;
	localparam int P_AM  = P_A + 1;
	localparam int P_Q   = P_AM + 1;
	localparam int P_SN  = P_Q + 1;
	localparam int P_SC  = P_SN + 2 * SN_N;
	localparam int P_PR  = P_SC + 1;
	localparam int P_SUM = P_PR + 1;
	localparam int P_RND = P_SUM + 1;
	localparam int DEPTH = P_RND + 1;

	// ---------------- configuration ----------------
	logic [8:0]  grid_width_q, grid_height_q;
	logic [16:0] twirl_strength_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q     <= 9'd64;
			grid_height_q    <= 9'd64;
			twirl_strength_q <= '0;
		end else if (cfg_wr) begin
			unique case (twirl_pkg::reg_idx_t'(paddr[3:2]))
				twirl_pkg::REG_GRID_WIDTH:     grid_width_q     <= pwdata[8:0];
				twirl_pkg::REG_GRID_HEIGHT:    grid_height_q    <= pwdata[8:0];
				twirl_pkg::REG_TWIRL_STRENGTH: twirl_strength_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (twirl_pkg::reg_idx_t'(paddr[3:2]))
			twirl_pkg::REG_GRID_WIDTH:     prdata = {23'b0, grid_width_q};
			twirl_pkg::REG_GRID_HEIGHT:    prdata = {23'b0, grid_height_q};
			twirl_pkg::REG_TWIRL_STRENGTH: prdata = {15'b0, twirl_strength_q};
			default:                       prdata = '0;
		endcase
	end

	// size minus one, with zero acting as one and oversize clamped
	logic [8:0] wm1, hm1;
	always_comb begin
		if (grid_width_q == 9'd0)
			wm1 = '0;
		else if (grid_width_q > 9'(twirl_pkg::MAX_GRID))
			wm1 = 9'(twirl_pkg::MAX_GRID - 1);
		else
			wm1 = grid_width_q - 9'd1;
		if (grid_height_q == 9'd0)
			hm1 = '0;
		else if (grid_height_q > 9'(twirl_pkg::MAX_GRID))
			hm1 = 9'(twirl_pkg::MAX_GRID - 1);
		else
			hm1 = grid_height_q - 9'd1;
	end

	// ---------------- handshake and valid line ----------------
	logic             adv, acc, push;
	logic [DEPTH-1:0] vld_q;
	logic             m_vld_q, sk_vld_q;
	logic [20:0]      res_s81, m_res_q, sk_res_q;

	assign adv           = !(m_vld_q && sk_vld_q);
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;
	assign push          = adv && vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[DEPTH-2:0], acc};
	end

	// ---------------- offsets ----------------
	twirl_pkg::off_t dx_in, dy_in;
	logic [21:0]     dxy_s [0:P_PR-1];

	assign dx_in = $signed({2'b0, s_axis_tdata[7:0], 1'b0}) - $signed({2'b0, wm1});
	assign dy_in = $signed({2'b0, s_axis_tdata[15:8], 1'b0}) - $signed({2'b0, hm1});

	always_ff @(posedge clk) begin
		if (adv) begin
			dxy_s[0] <= {dy_in, dx_in};
			for (int i = 1; i < P_PR; i++)
				dxy_s[i] <= dxy_s[i-1];
		end
	end

	// ---------------- squared radius ----------------
	twirl_pkg::off_t    dx1, dy1;
	logic signed [21:0] px2, py2;
	logic [17:0]        sqx_s2, sqy_s2;
	logic [18:0]        r2_s3;

	assign dx1 = dxy_s[0][10:0];
	assign dy1 = dxy_s[0][21:11];
	assign px2 = dx1 * dx1;
	assign py2 = dy1 * dy1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= px2[17:0];
			sqy_s2 <= py2[17:0];
			r2_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	logic [17:0] sq_rem_s  [0:SQ_N-1];
	logic [16:0] sq_root_s [0:SQ_N-1];
	logic [33:0] sq_v_s    [0:SQ_N-1];

	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		localparam int BI = 2 * (SQ_N - 1 - j);
		logic [17:0] rem_i;
		logic [16:0] root_i;
		logic [33:0] v_i;
		logic [19:0] cur, tst;

		if (j == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign v_i    = {1'b0, r2_s3, 14'b0};
		end else begin : g_next
			assign rem_i  = sq_rem_s[j-1];
			assign root_i = sq_root_s[j-1];
			assign v_i    = sq_v_s[j-1];
		end

		assign cur = {rem_i, v_i[BI+1:BI]};
		assign tst = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_v_s[j] <= v_i;
				if (cur >= tst) begin
					sq_rem_s[j]  <= 18'(cur - tst);
					sq_root_s[j] <= {root_i[15:0], 1'b1};
				end else begin
					sq_rem_s[j]  <= cur[17:0];
					sq_root_s[j] <= {root_i[15:0], 1'b0};
				end
			end
		end
	end

	// ---------------- r/22, then split by ln2 ----------------
	logic [48:0] u_prod;
	logic [20:0] u_s21, u_s22;
	logic [42:0] n_prod;
	logic [5:0]  n_s22, n_s23;
	logic [15:0] g_s23;

	assign u_prod = {sq_root_s[SQ_N-1], 7'b0} * twirl_pkg::RECIP_11;
	assign n_prod = u_s21 * twirl_pkg::RECIP_LN2;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s21 <= u_prod[48:28];
			u_s22 <= u_s21;
			n_s22 <= n_prod[42:37];
			g_s23 <= 16'(u_s22 - 21'(n_s22) * 21'(twirl_pkg::LN2_Q16));
			n_s23 <= n_s22;
		end
	end

	// ---------------- exp(-g) Taylor chain ----------------
	logic [29:0]        exm_p_s    [0:EX_N-1];
	logic signed [32:0] exm_sum_s  [0:EX_N-1];
	logic [15:0]        exm_g_s    [0:EX_N-1];
	logic [5:0]         exm_n_s    [0:EX_N-1];
	logic [30:0]        exd_term_s [0:EX_N-1];
	logic signed [32:0] exd_sum_s  [0:EX_N-1];
	logic [15:0]        exd_g_s    [0:EX_N-1];
	logic [5:0]         exd_n_s    [0:EX_N-1];

	for (genvar j = 0; j < EX_N; j++) begin : g_exp
		localparam int KD = j + 1;
		localparam int LK = $clog2(KD);
		localparam logic [31:0] MK = 32'(((64'd1 << (30 + LK)) + 64'(KD) - 64'd1) / 64'(KD));
		logic [30:0]        term_i;
		logic signed [32:0] sum_i;
		logic [15:0]        g_i;
		logic [5:0]         n_i;
		logic [60:0]        mp;
		logic [61:0]        dp;
		logic [30:0]        t;

		if (j == 0) begin : g_first
			assign term_i = 31'h4000_0000;
			assign sum_i  = 33'sh4000_0000;
			assign g_i    = g_s23;
			assign n_i    = n_s23;
		end else begin : g_next
			assign term_i = exd_term_s[j-1];
			assign sum_i  = exd_sum_s[j-1];
			assign g_i    = exd_g_s[j-1];
			assign n_i    = exd_n_s[j-1];
		end

		assign mp = term_i * {g_i, 14'b0};
		assign dp = exm_p_s[j] * MK;
		assign t  = 31'(dp >> (30 + LK));

		always_ff @(posedge clk) begin
			if (adv) begin
				exm_p_s[j]    <= mp[59:30];
				exm_sum_s[j]  <= sum_i;
				exm_g_s[j]    <= g_i;
				exm_n_s[j]    <= n_i;
				exd_term_s[j] <= t;
				exd_g_s[j]    <= exm_g_s[j];
				exd_n_s[j]    <= exm_n_s[j];
			end
		end

		if ((KD % 2) == 1) begin : g_sub
			always_ff @(posedge clk) begin
				if (adv)
					exd_sum_s[j] <= exm_sum_s[j] - $signed({2'b0, t});
			end
		end else begin : g_add
			always_ff @(posedge clk) begin
				if (adv)
					exd_sum_s[j] <= exm_sum_s[j] + $signed({2'b0, t});
			end
		end
	end

	// ---------------- e, angle, angle reduction ----------------
	logic signed [32:0] es;
	logic [31:0]        es_rnd;
	logic [16:0]        e_q16, e_s48;
	logic [20:0]        str9;
	logic [37:0]        a_prod;
	logic [20:0]        a_s49, am_c, am_s50;
	logic [1:0]         q_c, q_s51;
	logic [20:0]        x_c;
	logic [16:0]        x_s51;

	assign es     = exd_sum_s[EX_N-1];
	assign es_rnd = es[31:0] + 32'd8192;
	assign e_q16  = 17'(es_rnd >> 14);
	assign str9   = 21'({twirl_strength_q, 3'b0}) + 21'(twirl_strength_q);
	assign a_prod = str9 * e_s48;

	always_comb begin
		if (a_s49 >= 21'(2 * twirl_pkg::TWO_PI_Q16))
			am_c = a_s49 - 21'(2 * twirl_pkg::TWO_PI_Q16);
		else if (a_s49 >= twirl_pkg::TWO_PI_Q16)
			am_c = a_s49 - twirl_pkg::TWO_PI_Q16;
		else
			am_c = a_s49;
	end

	always_comb begin
		if (am_s50 >= 21'(3 * twirl_pkg::HALF_PI_Q16)) begin
			q_c = 2'd3;
			x_c = am_s50 - 21'(3 * twirl_pkg::HALF_PI_Q16);
		end else if (am_s50 >= 21'(2 * twirl_pkg::HALF_PI_Q16)) begin
			q_c = 2'd2;
			x_c = am_s50 - 21'(2 * twirl_pkg::HALF_PI_Q16);
		end else if (am_s50 >= twirl_pkg::HALF_PI_Q16) begin
			q_c = 2'd1;
			x_c = am_s50 - twirl_pkg::HALF_PI_Q16;
		end else begin
			q_c = 2'd0;
			x_c = am_s50;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (es[32] || (exd_n_s[EX_N-1] >= 6'd20))
				e_s48 <= '0;
			else
				e_s48 <= e_q16 >> exd_n_s[EX_N-1];
			a_s49  <= a_prod[36:16];
			am_s50 <= am_c;
			q_s51  <= q_c;
			x_s51  <= x_c[16:0];
		end
	end

	// ---------------- sin/cos Taylor chain ----------------
	logic [31:0]        snm_p_s    [0:SN_N-1];
	logic signed [34:0] snm_sn_s   [0:SN_N-1];
	logic signed [34:0] snm_cs_s   [0:SN_N-1];
	logic [30:0]        snm_x_s    [0:SN_N-1];
	logic [1:0]         snm_q_s    [0:SN_N-1];
	logic [30:0]        snd_term_s [0:SN_N-1];
	logic signed [34:0] snd_sn_s   [0:SN_N-1];
	logic signed [34:0] snd_cs_s   [0:SN_N-1];
	logic [30:0]        snd_x_s    [0:SN_N-1];
	logic [1:0]         snd_q_s    [0:SN_N-1];

	for (genvar j = 0; j < SN_N; j++) begin : g_sin
		localparam int KD = j + 2;
		localparam int LS = $clog2(KD);
		localparam logic [32:0] MS = 33'(((64'd1 << (32 + LS)) + 64'(KD) - 64'd1) / 64'(KD));
		logic [30:0]        term_i, x_i;
		logic signed [34:0] sn_i, cs_i;
		logic [1:0]         q_i;
		logic [61:0]        mp;
		logic [64:0]        dp;
		logic [30:0]        t;
		logic signed [34:0] ts;

		if (j == 0) begin : g_first
			assign term_i = {x_s51, 14'b0};
			assign x_i    = {x_s51, 14'b0};
			assign sn_i   = $signed({4'b0, x_s51, 14'b0});
			assign cs_i   = 35'sh4000_0000;
			assign q_i    = q_s51;
		end else begin : g_next
			assign term_i = snd_term_s[j-1];
			assign x_i    = snd_x_s[j-1];
			assign sn_i   = snd_sn_s[j-1];
			assign cs_i   = snd_cs_s[j-1];
			assign q_i    = snd_q_s[j-1];
		end

		assign mp = term_i * x_i;
		assign dp = snm_p_s[j] * MS;
		assign t  = 31'(dp >> (32 + LS));
		assign ts = $signed({4'b0, t});

		always_ff @(posedge clk) begin
			if (adv) begin
				snm_p_s[j]    <= mp[61:30];
				snm_sn_s[j]   <= sn_i;
				snm_cs_s[j]   <= cs_i;
				snm_x_s[j]    <= x_i;
				snm_q_s[j]    <= q_i;
				snd_term_s[j] <= t;
				snd_x_s[j]    <= snm_x_s[j];
				snd_q_s[j]    <= snm_q_s[j];
			end
		end

		// even powers feed cosine, odd powers sine; sign alternates every two
		if ((KD % 4) == 2) begin : g_cs_sub
			always_ff @(posedge clk) begin
				if (adv) begin
					snd_cs_s[j] <= snm_cs_s[j] - ts;
					snd_sn_s[j] <= snm_sn_s[j];
				end
			end
		end else if ((KD % 4) == 3) begin : g_sn_sub
			always_ff @(posedge clk) begin
				if (adv) begin
					snd_sn_s[j] <= snm_sn_s[j] - ts;
					snd_cs_s[j] <= snm_cs_s[j];
				end
			end
		end else if ((KD % 4) == 0) begin : g_cs_add
			always_ff @(posedge clk) begin
				if (adv) begin
					snd_cs_s[j] <= snm_cs_s[j] + ts;
					snd_sn_s[j] <= snm_sn_s[j];
				end
			end
		end else begin : g_sn_add
			always_ff @(posedge clk) begin
				if (adv) begin
					snd_sn_s[j] <= snm_sn_s[j] + ts;
					snd_cs_s[j] <= snm_cs_s[j];
				end
			end
		end
	end

	// ---------------- quadrant, rotation, rounding ----------------
	logic signed [34:0] sn_f, cs_f;
	logic [34:0]        sn_r, cs_r;
	logic signed [18:0] sv, cv, s_c, c_c, s_s78, c_s78;
	logic signed [29:0] cdx_s79, sdy_s79, sdx_s79, cdy_s79;
	logic signed [30:0] vx_s80, vy_s80;
	twirl_pkg::off_t    dx_pr, dy_pr;
	logic [30:0]        mag_x, mag_y;
	logic [13:0]        rx, ry;
	logic signed [14:0] sx, sy;
	logic [9:0]         sx_f, sy_f;
	logic               in_grid;

	assign sn_f = snd_sn_s[SN_N-1];
	assign cs_f = snd_cs_s[SN_N-1];
	assign sn_r = sn_f + 35'sd8192;
	assign cs_r = cs_f + 35'sd8192;
	assign sv   = sn_f[34] ? 19'sd0 : $signed({1'b0, sn_r[31:14]});
	assign cv   = cs_f[34] ? 19'sd0 : $signed({1'b0, cs_r[31:14]});

	always_comb begin
		case (snd_q_s[SN_N-1])
			2'd0: begin
				s_c = sv;
				c_c = cv;
			end
			2'd1: begin
				s_c = cv;
				c_c = -sv;
			end
			2'd2: begin
				s_c = -sv;
				c_c = -cv;
			end
			default: begin
				s_c = -cv;
				c_c = sv;
			end
		endcase
	end

	assign dx_pr = dxy_s[P_PR-1][10:0];
	assign dy_pr = dxy_s[P_PR-1][21:11];

	// round half away from zero on the magnitude
	assign mag_x = vx_s80[30] ? 31'(-vx_s80) : 31'(vx_s80);
	assign mag_y = vy_s80[30] ? 31'(-vy_s80) : 31'(vy_s80);
	assign rx    = 14'((mag_x + 31'd65536) >> 17);
	assign ry    = 14'((mag_y + 31'd65536) >> 17);
	assign sx    = vx_s80[30] ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
	assign sy    = vy_s80[30] ? -$signed({1'b0, ry}) : $signed({1'b0, ry});

	assign in_grid = !sx[14] && (sx <= $signed({6'b0, wm1}))
		&& !sy[14] && (sy <= $signed({6'b0, hm1}));

	always_comb begin
		if (sx > 15'sd511)
			sx_f = 10'h1FF;
		else if (sx < -15'sd512)
			sx_f = 10'h200;
		else
			sx_f = sx[9:0];
		if (sy > 15'sd511)
			sy_f = 10'h1FF;
		else if (sy < -15'sd512)
			sy_f = 10'h200;
		else
			sy_f = sy[9:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s78   <= s_c;
			c_s78   <= c_c;
			cdx_s79 <= c_s78 * dx_pr;
			sdy_s79 <= s_s78 * dy_pr;
			sdx_s79 <= s_s78 * dx_pr;
			cdy_s79 <= c_s78 * dy_pr;
			vx_s80  <= $signed({6'b0, wm1, 16'b0}) + cdx_s79 - sdy_s79;
			vy_s80  <= $signed({6'b0, hm1, 16'b0}) + sdx_s79 + cdy_s79;
			res_s81 <= {in_grid, sy_f, sx_f};
		end
	end

	// ---------------- output buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q  <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (!m_vld_q || m_axis_tready) begin
			if (sk_vld_q) begin
				m_vld_q  <= 1'b1;
				sk_vld_q <= push;
			end else begin
				m_vld_q <= push;
			end
		end else if (push) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_vld_q || m_axis_tready) begin
			if (sk_vld_q) begin
				m_res_q  <= sk_res_q;
				sk_res_q <= res_s81;
			end else begin
				m_res_q <= res_s81;
			end
		end else if (push) begin
			sk_res_q <= res_s81;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {4'b0, m_res_q[19:0]};
	assign m_axis_tuser  = m_res_q[20];

endmodule
